@@ rtl/core/i2d_pkg.sv @@
// ----------------------------------------------------------------------------
// i2d_pkg: shared constants for the binary to decimal text converter
// Character codes, digit width and the number of binary bits that the BCD
// adjust unit takes in per cycle.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int VALUE_WIDTH_DEF = 128;
  localparam int STEP_BITS       = 4;
  localparam int DIGIT_W         = 4;
  localparam int IN_HALF_W       = 64;
  localparam int CHAR_W          = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

endpackage

@@ rtl/core/int128_to_decimal_text.sv @@
// Sequence: the value is loaded, converted to BCD four bits at a time, a minus
// sign goes out if negative, then each decimal digit position is scanned in turn
// (39 for 128 bits); leading zero positions are scanned without a strobe.
// The next start is taken once the last character is on the outputs; no new word
// is taken before that. The receiver cannot stall the block.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
// int128_to_decimal_text: signed binary to decimal ASCII text
// Forms the unsigned magnitude, converts it to BCD with a shared
// shift-and-add-3 unit, then emits one character per strobe, a minus sign first if negative.
// ----------------------------------------------------------------------------
module int128_to_decimal_text #(
  parameter int VALUE_WIDTH = i2d_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [i2d_pkg::IN_HALF_W-1:0] in_value_high,
  input  logic [i2d_pkg::IN_HALF_W-1:0]        in_value_low,
  output logic                                out_valid,
  output logic [i2d_pkg::CHAR_W-1:0]           out_character,
  output logic                                out_last
);
  import i2d_pkg::*;

  localparam int PAD_W      = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int STEPS      = PAD_W / STEP_BITS;
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CNT_MAX    = (STEPS > NUM_DIGITS) ? STEPS : NUM_DIGITS;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [PAD_W-1:0]   bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic               neg_r;
  logic               started_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_character_r;
  logic               out_last_r;

  logic [2*IN_HALF_W-1:0] full_value;
  logic [VALUE_WIDTH-1:0] value;
  logic                   value_neg;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [BCD_W-1:0]       bcd_step;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   digit_last;

  assign full_value = {in_value_high, in_value_low};
  assign value      = full_value[VALUE_WIDTH-1:0];
  assign value_neg  = value[VALUE_WIDTH-1];
  // Taken as unsigned, so the most negative value yields 2^(VALUE_WIDTH-1).
  assign magnitude  = value_neg ? (~value + VALUE_WIDTH'(1)) : value;

  assign top_digit  = bcd_r[BCD_W-1 -: DIGIT_W];
  assign digit_last = (cnt_r == CNT_W'(NUM_DIGITS - 1));

  i2d_bcd_unit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_bcd_unit (
    .bcd_i  (bcd_r),
    .bits_i (bin_r[PAD_W-1 -: STEP_BITS]),
    .bcd_o  (bcd_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            bin_r     <= PAD_W'(magnitude);
            bcd_r     <= '0;
            neg_r     <= value_neg;
            cnt_r     <= '0;
            started_r <= 1'b0;
            state_r   <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_r <= bcd_step;
          bin_r <= bin_r << STEP_BITS;
          if (cnt_r == CNT_W'(STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= neg_r ? ST_SIGN : ST_EMIT;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_SIGN: begin
          out_valid_r     <= 1'b1;
          out_character_r <= CHAR_MINUS;
          out_last_r      <= 1'b0;
          state_r         <= ST_EMIT;
        end
        ST_EMIT: begin
          // Leading zero digits are passed over, but the final digit always goes out.
          if (top_digit != '0 || started_r || digit_last) begin
            out_valid_r     <= 1'b1;
            out_character_r <= CHAR_ZERO + CHAR_W'(top_digit);
            out_last_r      <= digit_last;
            started_r       <= 1'b1;
          end
          bcd_r <= bcd_r << DIGIT_W;
          if (digit_last) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  ((out_character >= CHAR_ZERO) && (out_character <= CHAR_ZERO + 6'd9)))
    else $error("character outside the minus sign and digit codes");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("word strobed right after the final character");
`endif

endmodule

@@ rtl/core/i2d_bcd_unit.sv @@
// ----------------------------------------------------------------------------
// i2d_bcd_unit: shift-and-add-3 step of the binary to BCD conversion
// Shifts STEP_BITS binary bits into a packed BCD register, adjusting every
// digit that is five or more before each single-bit shift.
// ----------------------------------------------------------------------------
module i2d_bcd_unit #(
  parameter int NUM_DIGITS = 39
) (
  input  logic [NUM_DIGITS*i2d_pkg::DIGIT_W-1:0] bcd_i,
  input  logic [i2d_pkg::STEP_BITS-1:0]          bits_i,
  output logic [NUM_DIGITS*i2d_pkg::DIGIT_W-1:0] bcd_o
);
  import i2d_pkg::*;

  localparam int BCD_W = NUM_DIGITS * DIGIT_W;

  always_comb begin
    logic [BCD_W-1:0]   acc;
    logic [DIGIT_W-1:0] dig;
    acc = bcd_i;
    for (int s = 0; s < STEP_BITS; s++) begin
      // Digits are adjusted independently, then the whole word shifts by one.
      for (int d = 0; d < NUM_DIGITS; d++) begin
        dig = acc[d*DIGIT_W +: DIGIT_W];
        if (dig >= DIGIT_W'(5)) begin
          acc[d*DIGIT_W +: DIGIT_W] = dig + DIGIT_W'(3);
        end
      end
      acc = {acc[BCD_W-2:0], bits_i[STEP_BITS-1-s]};
    end
    bcd_o = acc;
  end

endmodule
